FILE: rtl/core/mme_pkg.sv
// Shared types and constants of the matrix multiply engine.
package mme_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;

    localparam logic [1:0] ACT_LOAD_A  = 2'd0;
    localparam logic [1:0] ACT_LOAD_B  = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;

    localparam logic [1:0] REG_ROWS_A = 2'd0;
    localparam logic [1:0] REG_COLS_A = 2'd1;
    localparam logic [1:0] REG_ROWS_B = 2'd2;
    localparam logic [1:0] REG_COLS_B = 2'd3;

    typedef enum logic [1:0] {
        CMD_LOAD_A,
        CMD_LOAD_B,
        CMD_COMPUTE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [15:0] value;
    } cmd_t;

    // Clamped matrix dimensions, each 1..8
    typedef struct packed {
        logic [3:0] rows_a;
        logic [3:0] cols_a;
        logic [3:0] rows_b;
        logic [3:0] cols_b;
    } dims_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_MISMATCH
    } back_state_t;

endpackage

FILE: rtl/core/matrix_multiply_engine_unit.sv
// Top level of the matrix multiply engine: configuration registers and the two halves.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+---------------------------------------
//  s_*     | in        | s_tvalid/s_tready  | s_tdata: action, row, col, value
//  m_*     | out       | m_tvalid/m_tready  | m_tdata: product, out_row, out_col;
//          |           |                    | m_tlast: last; m_tuser: mismatch
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
//  A load is written into its element store as it leaves the queue; a compute issues one
//  multiply-accumulate per cycle while the result slot is not blocked, through a
//  read/multiply/accumulate pipeline fed by the single read port of each element store.
//  A mismatch compute yields its single item once the result slot is free after it leaves the queue.
//  A four-entry command queue lets loads and computes be accepted while work is running.
//  Reset clears control state and sets all dimensions to 1; element stores are not cleared.
//  A stalled output holds the pipeline; the queue keeps accepting until it fills.
module matrix_multiply_engine_unit
    import mme_pkg::*;
#(
    parameter int unsigned MAX_DIM = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // action[1:0], row[4:2], col[7:5], value[23:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // product[33:0], out_row[36:34], out_col[39:37]
    output logic        m_tlast,   // last
    output logic        m_tuser,   // mismatch
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    localparam int unsigned DIM_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;
    localparam logic [3:0]  CAP_W   = 4'(DIM_CAP);

    logic [3:0] rows_a_reg;
    logic [3:0] cols_a_reg;
    logic [3:0] rows_b_reg;
    logic [3:0] cols_b_reg;
    dims_t      dims;
    logic       cmd_valid;
    cmd_t       cmd;
    logic       cmd_pop;

    function automatic logic [3:0] clamp_dim(input logic [3:0] v);
        logic [3:0] r;
        if (v == 4'd0)
        begin
            r = 4'd1;
        end
        else if (v > CAP_W)
        begin
            r = CAP_W;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg <= 4'd1;
            cols_a_reg <= 4'd1;
            rows_b_reg <= 4'd1;
            cols_b_reg <= 4'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROWS_A: rows_a_reg <= cfg_data;
                REG_COLS_A: cols_a_reg <= cfg_data;
                REG_ROWS_B: rows_b_reg <= cfg_data;
                REG_COLS_B: cols_b_reg <= cfg_data;
                default:    rows_a_reg <= rows_a_reg;
            endcase
        end
    end

    assign dims.rows_a = clamp_dim(rows_a_reg);
    assign dims.cols_a = clamp_dim(cols_a_reg);
    assign dims.rows_b = clamp_dim(rows_b_reg);
    assign dims.cols_b = clamp_dim(cols_b_reg);

    mme_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    mme_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .dims      (dims),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: rtl/core/mme_front.sv
// Input side: accepts items, drops unused ones and queues commands.
module mme_front
    import mme_pkg::*;
#(
    parameter int unsigned MAX_DIM = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // action[1:0], row[4:2], col[7:5], value[23:8]
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_pop
);

    cmd_t                q_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;

    logic [1:0]          in_action;
    logic [2:0]          in_row;
    logic [2:0]          in_col;
    logic                in_range;
    logic                keep;
    logic                push;
    cmd_t                new_cmd;

    assign in_action = s_tdata[1:0];
    assign in_row    = s_tdata[4:2];
    assign in_col    = s_tdata[7:5];

    assign s_tready  = (count_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];

    always_comb
    begin
        in_range      = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
        new_cmd.row   = in_row;
        new_cmd.col   = in_col;
        new_cmd.value = s_tdata[23:8];
        new_cmd.kind  = CMD_COMPUTE;
        keep          = 1'b0;
        case (in_action)
            ACT_LOAD_A:
            begin
                new_cmd.kind = CMD_LOAD_A;
                keep         = in_range;
            end
            ACT_LOAD_B:
            begin
                new_cmd.kind = CMD_LOAD_B;
                keep         = in_range;
            end
            ACT_COMPUTE:
            begin
                new_cmd.kind = CMD_COMPUTE;
                keep         = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // Drop loads outside storage and unused actions at the door
    assign push = s_tvalid && s_tready && keep;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

FILE: rtl/core/mme_back.sv
// Execution side: element stores, multiply-accumulate pipeline, result register.
module mme_back
    import mme_pkg::*;
#(
    parameter int unsigned MAX_DIM = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dims_t       dims,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // product[33:0], out_row[36:34], out_col[39:37]
    output logic        m_tlast,   // last
    output logic        m_tuser    // mismatch
);

    localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] DIM_W = AW'(MAX_DIM);

    localparam logic signed [34:0] PROD_MAX = 35'sh1_FFFF_FFFF;
    localparam logic signed [34:0] PROD_MIN = -35'sh2_0000_0000;

    typedef struct packed {
        logic       first;
        logic       last_k;
        logic       last_elem;
        logic [2:0] i;
        logic [2:0] j;
    } tag_t;

    logic signed [15:0] mem_a [DEPTH];
    logic signed [15:0] mem_b [DEPTH];

    back_state_t state_reg;
    back_state_t state_next;
    logic [2:0]  i_reg;
    logic [2:0]  i_next;
    logic [2:0]  j_reg;
    logic [2:0]  j_next;
    logic [2:0]  k_reg;
    logic [2:0]  k_next;

    logic        wr_a;
    logic        wr_b;
    logic        issue;
    logic        load_mis;
    logic        load_pipe;
    logic        adv;
    logic        out_free;

    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    logic [2:0]    ra_last;
    logic [2:0]    ca_last;
    logic [2:0]    cb_last;
    tag_t          issue_tag;

    logic               s1_valid_reg;
    tag_t               s1_tag_reg;
    logic signed [15:0] a_rd_reg;
    logic signed [15:0] b_rd_reg;
    logic               s2_valid_reg;
    tag_t               s2_tag_reg;
    logic signed [31:0] prod_reg;
    logic signed [34:0] acc_reg;
    logic signed [34:0] sum;
    logic signed [33:0] sat_sum;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [33:0] out_prod_reg;
    logic [2:0]         out_row_reg;
    logic [2:0]         out_col_reg;
    logic               out_last_reg;
    logic               out_mis_reg;

    assign ra_last = 3'(dims.rows_a - 4'd1);
    assign ca_last = 3'(dims.cols_a - 4'd1);
    assign cb_last = 3'(dims.cols_b - 4'd1);

    assign out_free  = !out_valid_reg || m_tready;
    // Hold the whole pipeline while a finished element waits for the result slot
    assign adv       = !(s2_valid_reg && s2_tag_reg.last_k && !out_free);
    assign load_pipe = adv && s2_valid_reg && s2_tag_reg.last_k;

    assign waddr   = AW'(cmd.row) * DIM_W + AW'(cmd.col);
    assign raddr_a = AW'(i_reg) * DIM_W + AW'(k_reg);
    assign raddr_b = AW'(k_reg) * DIM_W + AW'(j_reg);

    assign issue_tag.first     = (k_reg == 3'd0);
    assign issue_tag.last_k    = (k_reg == ca_last);
    assign issue_tag.last_elem = (i_reg == ra_last) && (j_reg == cb_last);
    assign issue_tag.i         = i_reg;
    assign issue_tag.j         = j_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        cmd_pop    = 1'b0;
        wr_a       = 1'b0;
        wr_b       = 1'b0;
        issue      = 1'b0;
        load_mis   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        CMD_LOAD_A:
                        begin
                            wr_a = 1'b1;
                        end
                        CMD_LOAD_B:
                        begin
                            wr_b = 1'b1;
                        end
                        CMD_COMPUTE:
                        begin
                            i_next = '0;
                            j_next = '0;
                            k_next = '0;
                            if (dims.cols_a != dims.rows_b)
                            begin
                                state_next = ST_MISMATCH;
                            end
                            else
                            begin
                                state_next = ST_ISSUE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ISSUE:
            begin
                if (adv)
                begin
                    issue = 1'b1;
                    // advance k, then j, then i
                    if (k_reg == ca_last)
                    begin
                        k_next = '0;
                        if (j_reg == cb_last)
                        begin
                            j_next = '0;
                            if (i_reg == ra_last)
                            begin
                                state_next = ST_DRAIN;
                            end
                            else
                            begin
                                i_next = i_reg + 3'd1;
                            end
                        end
                        else
                        begin
                            j_next = j_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        k_next = k_reg + 3'd1;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (load_pipe && s2_tag_reg.last_elem)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MISMATCH:
            begin
                if (out_free)
                begin
                    load_mis   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[waddr] <= cmd.value;
        end
        if (adv)
        begin
            a_rd_reg <= mem_a[raddr_a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
        begin
            mem_b[waddr] <= cmd.value;
        end
        if (adv)
        begin
            b_rd_reg <= mem_b[raddr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_tag_reg <= issue_tag;
            s2_tag_reg <= s1_tag_reg;
            prod_reg   <= a_rd_reg * b_rd_reg;
            if (s2_valid_reg)
            begin
                acc_reg <= sum;
            end
        end
    end

    always_comb
    begin
        sum = (s2_tag_reg.first ? 35'sd0 : acc_reg) + {{3{prod_reg[31]}}, prod_reg};
        if (sum > PROD_MAX)
        begin
            sat_sum = PROD_MAX[33:0];
        end
        else if (sum < PROD_MIN)
        begin
            sat_sum = PROD_MIN[33:0];
        end
        else
        begin
            sat_sum = sum[33:0];
        end
    end

    always_comb
    begin
        if (load_pipe || load_mis)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_pipe)
        begin
            out_prod_reg <= sat_sum;
            out_row_reg  <= s2_tag_reg.i;
            out_col_reg  <= s2_tag_reg.j;
            out_last_reg <= s2_tag_reg.last_elem;
            out_mis_reg  <= 1'b0;
        end
        else if (load_mis)
        begin
            out_prod_reg <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_last_reg <= 1'b1;
            out_mis_reg  <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_col_reg, out_row_reg, out_prod_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_mis_reg;

endmodule
